/* sv/stid_pkg.sv */
// shared types and constants for the sorted table insert/delete block
// no dependencies; used by stid_cell and sorted_table_insert_delete
package stid_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;
   localparam int POS_W            = 4;
   localparam int POS_SPAN         = 2 ** POS_W;
   localparam int COUNT_W          = 5;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] read_value;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      ins;
      logic                      del;
   } cell_cmd_type;

   // per-cell compare results
   typedef struct packed {
      logic lt;
      logic eq_first;
   } cell_flags_type;

endpackage

/* sv/sorted_table_insert_delete.sv */
// top level of the sorted table: a chain of compare-and-shift cells plus result register
// depends on stid_pkg and stid_cell
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of cells, one
// entry per cell. Every cell compares its entry with the beat's value at once, so an
// insert, a delete or a read is applied by all cells together: one operation per clock is
// accepted while the result register can take it, and its result appears in the output
// register on the following cycle. The single result register is the only thing that sets
// the rate; a new beat is taken whenever that register is empty or being drained in the
// same cycle. Insert goes in front of equal entries, delete removes the first equal entry,
// read returns the entry at the given position, and only the first 16 positions can be
// read. Count is reported on 5 bits.
module sorted_table_insert_delete #(
   parameter int CAPACITY = stid_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stid_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stid_pkg::rsp_type rsp_data
);
   import stid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // entry count and handshake state
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;

   // cell row
   cell_cmd_type              cmd;
   logic [CAPACITY-1:0]       cell_valid;
   logic [CAPACITY-1:0]       eq_vec;
   cell_flags_type            cell_flags [CAPACITY];
   logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
   logic signed [VALUE_W-1:0] rd_arr     [POS_SPAN];

   logic                      req_fire;
   logic                      full;
   logic                      found;
   logic                      pos_ok;
   logic [CMP_W-1:0]          pos_x;
   logic [CMP_W-1:0]          cnt_x;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign found     = |eq_vec;

   // broadcast command: shift only when the operation really changes the table
   always_comb begin
      cmd.value = req_data.value;
      cmd.ins   = req_fire && (req_data.op == OP_INSERT) && !full;
      cmd.del   = req_fire && (req_data.op == OP_DELETE) && found;
   end

   // the chain: each cell sees its neighbors' entries and the left neighbor's compare
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      prev_lt;
      logic signed [VALUE_W-1:0] prev_entry;
      logic signed [VALUE_W-1:0] next_entry;

      assign cell_valid[i] = (CNT_W'(i) < count_ff);
      assign eq_vec[i]     = cell_flags[i].eq_first;

      if (i == 0) begin : g_head
         // nothing in front of the first cell
         assign prev_lt    = 1'b1;
         assign prev_entry = req_data.value;
      end else begin : g_body
         assign prev_lt    = cell_flags[i-1].lt;
         assign prev_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         // last cell empties on delete
         assign next_entry = '0;
      end else begin : g_link
         assign next_entry = cell_entry[i+1];
      end

      stid_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .valid      (cell_valid[i]),
         .prev_lt    (prev_lt),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .flags      (cell_flags[i]),
         .entry      (cell_entry[i])
      );
   end

   // read port covers the positions the 4-bit field can address
   for (genvar j = 0; j < POS_SPAN; j++) begin : g_rd
      if (j < CAPACITY) begin : g_cell_tap
         assign rd_arr[j] = cell_entry[j];
      end else begin : g_pad
         assign rd_arr[j] = '0;
      end
   end

   assign pos_x  = CMP_W'(req_data.position);
   assign cnt_x  = CMP_W'(count_ff);
   assign pos_ok = (pos_x < cnt_x);

   // next count
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.del) begin
         count_in = count_ff - 1'b1;
      end
   end

   // result for the beat being accepted
   always_comb begin
      rsp_in.status     = ST_OK;
      rsp_in.count      = COUNT_W'(count_in);
      rsp_in.read_value = '0;
      unique case (req_data.op)
         OP_INSERT: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end
         end
         OP_DELETE: begin
            if (!found) begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end
         OP_READ: begin
            if (pos_ok) begin
               rsp_in.read_value = rd_arr[req_data.position];
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         default: begin
            // unused code: no change, plain ok
            rsp_in.status = ST_OK;
         end
      endcase
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded on accept
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // insert and delete never shift in the same cycle
   a_one_shift: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins && cmd.del))
      else $error("insert and delete shift together");

   // a successful insert grows the table by one
   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the count");

   // at most one cell claims the first match
   a_one_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(eq_vec))
      else $error("several cells claim the first match");

   // stored entries stay in ascending order
   for (genvar k = 1; k < CAPACITY; k++) begin : g_order_chk
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         cell_valid[k] |-> cell_entry[k-1] <= cell_entry[k])
         else $error("table out of order");
   end

endmodule

/* sv/stid_cell.sv */
// one compare-and-shift cell of the sorted table chain
// depends on stid_pkg
module stid_cell (
   input  logic                                  clock,
   input  stid_pkg::cell_cmd_type                cmd,
   input  logic                                  valid,
   input  logic                                  prev_lt,
   input  logic signed [stid_pkg::VALUE_W-1:0]   prev_entry,
   input  logic signed [stid_pkg::VALUE_W-1:0]   next_entry,
   output stid_pkg::cell_flags_type              flags,
   output logic signed [stid_pkg::VALUE_W-1:0]   entry
);
   import stid_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      lt;
   logic                      write;

   always_comb begin
      lt             = valid && (entry_ff < cmd.value);
      flags.lt       = lt;
      // first matching entry: everything in front of it is smaller
      flags.eq_first = valid && (entry_ff == cmd.value) && prev_lt;
      // cells at or past the slot move, cells in front stay
      write          = (cmd.ins || cmd.del) && !lt;
      if (cmd.del) begin
         entry_in = next_entry;
      end else if (prev_lt) begin
         entry_in = cmd.value;
      end else begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (write) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

/* dv/sorted_table_insert_delete_tb.sv */
// testbench for sorted_table_insert_delete: directed and random insert/delete/read beats
// depends on stid_pkg and the sorted_table_insert_delete rtl; self-checking, no files read
module sorted_table_insert_delete_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stid_pkg::*;

   localparam int         CAPACITY   = DEFAULT_CAPACITY;
   localparam logic [1:0] OP_UNUSED  = 2'd3;   // no-op code, table left alone
   localparam int         MAX_SHOWN  = 10;
   localparam int         RANDOM_OPS = 1880;   // counted ops only, no-ops excluded
   localparam int         DRAIN_GAP  = 5;

   // tracks the table contents and the results still owed by the block
   class table_tracker;
      logic signed [VALUE_W-1:0] slots[CAPACITY];
      int unsigned               fill;
      rsp_type                   awaited[$];
      int unsigned               errors;
      int unsigned               checked;
      int unsigned               status_seen[4];

      function new();
         fill    = 0;
         errors  = 0;
         checked = 0;
         foreach (slots[i]) slots[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // apply one accepted request to the table copy and queue its result
      function void note_request(req_type r);
         rsp_type want;
         int      slot;
         int      k;
         want = '0;
         want.status = ST_OK;
         case (r.op)
            OP_INSERT: begin
               if (fill >= CAPACITY) begin
                  want.status = ST_FULL;
               end else begin
                  // equal values land in front of the ones already stored
                  slot = 0;
                  while (slot < fill && slots[slot] < r.value) slot++;
                  for (k = fill; k > slot; k--) slots[k] = slots[k-1];
                  slots[slot] = r.value;
                  fill++;
               end
            end
            OP_DELETE: begin
               slot = 0;
               while (slot < fill && slots[slot] != r.value) slot++;
               if (slot >= fill) begin
                  want.status = ST_NOT_FOUND;
               end else begin
                  for (k = slot; k + 1 < fill; k++) slots[k] = slots[k+1];
                  fill--;
                  slots[fill] = '0;
               end
            end
            OP_READ: begin
               if (r.position < fill) want.read_value = slots[r.position];
               else want.status = ST_RANGE;
            end
            default: ;
         endcase
         want.count = fill[COUNT_W-1:0];
         status_seen[want.status]++;
         awaited.push_back(want);
      endfunction

      // compare one result beat with the oldest owed result
      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display("result beat with nothing owed: status %0d count %0d read_value %0d",
                        got.status, got.count, got.read_value);
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.status !== want.status || got.count !== want.count ||
             got.read_value !== want.read_value) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display({"result %0d: expected status %0d count %0d read_value %0d,",
                         " got status %0d count %0d read_value %0d"},
                        checked, want.status, want.count, want.read_value,
                        got.status, got.count, got.read_value);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   table_tracker tracker;
   int           req_idle_pct;
   int           rsp_stall_pct;
   int unsigned  beats_sent;
   bit           filling;

   sorted_table_insert_delete uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #2_000_000;
      $display("sorted_table_insert_delete: mismatch");
      $finish;
   end

   // result side: ready changes on the falling edge, stalls drawn per cycle
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // result beats are taken at the rising edge where valid and ready meet
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_data);
   end

   function automatic req_type make_req(logic [1:0] op, logic signed [VALUE_W-1:0] value,
                                        logic [POS_W-1:0] position);
      req_type r;
      r.op       = op;
      r.value    = value;
      r.position = position;
      return r;
   endfunction

   // half the time from a small pool so duplicates and delete hits are common
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5) return $signed($urandom_range(8)) - 4;
      if (sel == 5) begin
         case ($urandom_range(3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // random op whose mix follows a fill/drain trend so the count sweeps 0..capacity
   function automatic req_type next_random_request();
      req_type r;
      int      roll;
      if (tracker.fill == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      if (tracker.fill == 0) filling = 1'b1;
      r.value    = pick_value();
      r.position = POS_W'($urandom_range(POS_SPAN - 1));
      roll       = $urandom_range(99);
      if (roll < 3)                     r.op = OP_UNUSED;
      else if (roll < (filling ? 60 : 25)) r.op = OP_INSERT;
      else if (roll < (filling ? 80 : 70)) r.op = OP_DELETE;
      else                              r.op = OP_READ;
      // deletes usually name something stored, reads usually land inside the count
      if (r.op == OP_DELETE && tracker.fill > 0 && $urandom_range(99) < 65)
         r.value = tracker.slots[$urandom_range(tracker.fill - 1)];
      if (r.op == OP_READ && tracker.fill > 0 && $urandom_range(99) < 70)
         r.position = POS_W'($urandom_range(tracker.fill - 1));
      return r;
   endfunction

   // present one beat from a falling edge, hold until accepted, return on the next falling edge
   task automatic push_request(input req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(item);
      beats_sent++;
      @(negedge clock);
   endtask

   initial begin
      req_type directed[$];
      req_type item;
      int      idle_mix[4];
      int      stall_mix[4];
      int      counted;

      idle_mix      = '{0, 65, 0, 34};
      stall_mix     = '{0, 0, 65, 34};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      beats_sent    = 0;
      filling       = 1'b1;
      tracker       = new();

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, duplicates, ordering, misses and the no-op code
      directed.push_back(make_req(OP_READ,   32'sh0,         4'd0));   // read on empty
      directed.push_back(make_req(OP_DELETE, 32'sd5,         4'd0));   // delete on empty
      directed.push_back(make_req(OP_INSERT, 32'sh7fff_ffff, 4'd0));
      directed.push_back(make_req(OP_INSERT, 32'sh8000_0000, 4'd15));
      directed.push_back(make_req(OP_INSERT, 32'sh0,         4'd0));
      directed.push_back(make_req(OP_INSERT, -32'sd1,        4'd0));
      directed.push_back(make_req(OP_INSERT, 32'sh0,         4'd0));   // duplicate goes in front
      directed.push_back(make_req(OP_INSERT, 32'sd1,         4'd0));
      directed.push_back(make_req(OP_READ,   32'sh0,         4'd0));   // most negative
      directed.push_back(make_req(OP_READ,   32'sh0,         4'd5));   // most positive
      directed.push_back(make_req(OP_READ,   32'sh0,         4'd6));   // exactly at the count
      directed.push_back(make_req(OP_READ,   32'shffff_ffff, 4'd15));  // far out of range
      directed.push_back(make_req(OP_UNUSED, 32'shffff_ffff, 4'd15));  // no-op, all ones
      directed.push_back(make_req(OP_DELETE, 32'sh0,         4'd0));   // removes first equal
      directed.push_back(make_req(OP_DELETE, 32'sd7,         4'd0));   // absent value
      directed.push_back(make_req(OP_DELETE, 32'sh8000_0000, 4'd0));
      directed.push_back(make_req(OP_DELETE, 32'sh7fff_ffff, 4'd0));
      directed.push_back(make_req(OP_READ,   32'sh0,         4'd2));
      directed.push_back(make_req(OP_UNUSED, 32'sh0,         4'd0));   // no-op, all zeros
      foreach (directed[i]) push_request(directed[i]);

      // random part in four handshake mixes: none, sender gaps, receiver stalls, both
      for (int phase = 0; phase < 4; phase++) begin
         req_idle_pct  = idle_mix[phase];
         rsp_stall_pct = stall_mix[phase];
         counted       = 0;
         while (counted < RANDOM_OPS / 4) begin
            item = next_random_request();
            push_request(item);
            if (item.op != OP_UNUSED) counted++;
         end
      end
      req_valid <= 1'b0;

      // drain every owed result, then give the output register time to misbehave
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);

      $display("%0d request beats in four handshake mixes, %0d results checked",
               beats_sent, tracker.checked);
      $display("full refusals %0d, delete misses %0d, out-of-range reads %0d",
               tracker.status_seen[ST_FULL], tracker.status_seen[ST_NOT_FOUND],
               tracker.status_seen[ST_RANGE]);
      if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
         $display("sorted_table_insert_delete: match");
      end else begin
         $display("%0d mismatches in total", tracker.errors);
         $display("sorted_table_insert_delete: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/stid_pkg.sv
sv/stid_cell.sv
sv/sorted_table_insert_delete.sv
dv/sorted_table_insert_delete_tb.sv
